// ===== design/hkr_pkg.sv =====
// Shared types, constants and lookup functions for the keyboard report translator.
package hkr_pkg;

	localparam int          MAX_SLOTS     = 6;
	localparam int          KEY_SLOTS_DEF = 6;
	localparam logic [7:0]  KC_ROLLOVER   = 8'h01;
	localparam logic [7:0]  SEQ_FIRST     = 8'h3A;
	localparam logic [7:0]  SEQ_LAST      = 8'h52;
	localparam logic [7:0]  TABLE_SIZE    = 8'h39;
	localparam logic [7:0]  SHIFT_MASK    = 8'h22;
	localparam logic [7:0]  CTRL_MASK     = 8'h11;
	localparam logic [6:0]  ESC           = 7'h1B;

	// per-slot result of the classify step
	typedef struct packed {
		logic [4:0] seq_idx;
		logic [6:0] chr;
	} slot_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [4:0][6:0] b;
	} seq_t;

	// escape sequence for a keycode offset from F1; len 0 means none
	function automatic seq_t seq_lookup(input logic [4:0] idx);
		seq_t s;
		s.len  = 3'd3;
		s.b    = '0;
		s.b[0] = ESC;
		s.b[1] = 7'h5B;
		unique case (idx) inside
			[5'd0:5'd3]: begin
				s.b[1] = 7'h4F;
				s.b[2] = 7'(7'h50 + {2'b00, idx});
			end
			5'd4: begin s.len = 3'd5; s.b[2] = 7'h31; s.b[3] = 7'h35; s.b[4] = 7'h7E; end
			5'd5: begin s.len = 3'd5; s.b[2] = 7'h31; s.b[3] = 7'h37; s.b[4] = 7'h7E; end
			5'd6: begin s.len = 3'd5; s.b[2] = 7'h31; s.b[3] = 7'h38; s.b[4] = 7'h7E; end
			5'd7: begin s.len = 3'd5; s.b[2] = 7'h31; s.b[3] = 7'h39; s.b[4] = 7'h7E; end
			5'd8: begin s.len = 3'd5; s.b[2] = 7'h32; s.b[3] = 7'h30; s.b[4] = 7'h7E; end
			5'd9: begin s.len = 3'd5; s.b[2] = 7'h32; s.b[3] = 7'h31; s.b[4] = 7'h7E; end
			5'd10: begin s.len = 3'd5; s.b[2] = 7'h32; s.b[3] = 7'h33; s.b[4] = 7'h7E; end
			5'd11: begin s.len = 3'd5; s.b[2] = 7'h32; s.b[3] = 7'h34; s.b[4] = 7'h7E; end
			5'd15: begin s.len = 3'd4; s.b[2] = 7'h32; s.b[3] = 7'h7E; end
			5'd16: s.b[2] = 7'h48;
			5'd17: begin s.len = 3'd4; s.b[2] = 7'h35; s.b[3] = 7'h7E; end
			5'd18: begin s.len = 3'd4; s.b[2] = 7'h33; s.b[3] = 7'h7E; end
			5'd19: s.b[2] = 7'h46;
			5'd20: begin s.len = 3'd4; s.b[2] = 7'h36; s.b[3] = 7'h7E; end
			5'd21: s.b[2] = 7'h43;
			5'd22: s.b[2] = 7'h44;
			5'd23: s.b[2] = 7'h42;
			5'd24: s.b[2] = 7'h41;
			default: s.len = 3'd0;
		endcase
		return s;
	endfunction

	// US layout character for a keycode, 0 when unmapped
	function automatic logic [6:0] key_char(input logic [7:0] kc, input logic [7:0] mods);
		logic       shift;
		logic       ctrl;
		logic [6:0] ch;
		shift = |(mods & SHIFT_MASK);
		ctrl  = |(mods & CTRL_MASK);
		ch    = '0;
		if (kc >= 8'h04 && kc <= 8'h1D) begin
			if (ctrl)
				ch = 7'(kc - 8'h03);
			else if (shift)
				ch = 7'(kc + 8'h3D);
			else
				ch = 7'(kc + 8'h5D);
		end else if (kc < TABLE_SIZE) begin
			unique case (kc)
				8'h1E: ch = shift ? 7'h21 : 7'h31;
				8'h1F: ch = shift ? 7'h40 : 7'h32;
				8'h20: ch = shift ? 7'h23 : 7'h33;
				8'h21: ch = shift ? 7'h24 : 7'h34;
				8'h22: ch = shift ? 7'h25 : 7'h35;
				8'h23: ch = shift ? 7'h5E : 7'h36;
				8'h24: ch = shift ? 7'h26 : 7'h37;
				8'h25: ch = shift ? 7'h2A : 7'h38;
				8'h26: ch = shift ? 7'h28 : 7'h39;
				8'h27: ch = shift ? 7'h29 : 7'h30;
				8'h28: ch = 7'h0A;
				8'h29: ch = ESC;
				8'h2A: ch = 7'h08;
				8'h2B: ch = 7'h09;
				8'h2C: ch = 7'h20;
				8'h2D: ch = shift ? 7'h5F : 7'h2D;
				8'h2E: ch = shift ? 7'h2B : 7'h3D;
				8'h2F: ch = shift ? 7'h7B : 7'h5B;
				8'h30: ch = shift ? 7'h7D : 7'h5D;
				8'h31: ch = shift ? 7'h7C : 7'h5C;
				8'h33: ch = shift ? 7'h3A : 7'h3B;
				8'h34: ch = shift ? 7'h22 : 7'h27;
				8'h35: ch = shift ? 7'h7E : 7'h60;
				8'h36: ch = shift ? 7'h3C : 7'h2C;
				8'h37: ch = shift ? 7'h3E : 7'h2E;
				8'h38: ch = shift ? 7'h3F : 7'h2F;
				default: ch = '0;
			endcase
		end
		return ch;
	endfunction

endpackage

// ===== design/hkr_classify.sv =====
// Newly-pressed detection and per-slot escape / character lookup for one report.
module hkr_classify #(
	parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
	input  logic [KEY_SLOTS-1:0][7:0] keys,
	input  logic [KEY_SLOTS-1:0][7:0] prev,
	input  logic [7:0]                mods,
	output hkr_pkg::slot_t            info [KEY_SLOTS],
	output logic [KEY_SLOTS-1:0]      seq_mask,
	output logic [KEY_SLOTS-1:0]      chr_mask
);
	import hkr_pkg::*;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic  held;
			logic  in_seq;
			logic  fresh;
			seq_t  s;
			held = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++)
				if (prev[j] == keys[i])
					held = 1'b1;
			fresh           = (keys[i] != 8'h00) && !held;
			info[i].seq_idx = 5'(keys[i] - SEQ_FIRST);
			info[i].chr     = key_char(keys[i], mods);
			s               = seq_lookup(info[i].seq_idx);
			in_seq          = (keys[i] >= SEQ_FIRST) && (keys[i] <= SEQ_LAST) &&
			                  (s.len != 3'd0);
			seq_mask[i]     = fresh && in_seq;
			chr_mask[i]     = fresh && !in_seq && (info[i].chr != 7'd0);
		end
	end

endmodule

// ===== design/hid_keyboard_report_to_ascii.sv =====
// Top level: boot keyboard report in, ASCII / VT100 byte stream out.
// A report beat is classified in the cycle it is accepted: each slot is checked
// against the keys of the previous report, and new keys are looked up in the
// escape and character tables. Bytes then leave through a registered output at
// one per cycle unless stalled: first the escape sequences of new keys in slot
// order, then the characters, with last_byte on the final one. A report
// therefore occupies the emitter until its bytes (zero to thirty) have left,
// and the next report is taken in the cycle its predecessor's last byte moves
// into the output register, or at once when the emitter is empty. Short reports
// and rollover errors are accepted, give no bytes and keep the stored keys.
module hid_keyboard_report_to_ascii #(
	parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       report_valid,
	output logic       report_stall,
	input  logic [7:0] modifier_mask,
	input  logic [7:0] key_0,
	input  logic [7:0] key_1,
	input  logic [7:0] key_2,
	input  logic [7:0] key_3,
	input  logic [7:0] key_4,
	input  logic [7:0] key_5,
	input  logic       short_report,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [6:0] out_byte,
	output logic       last_byte
);
	import hkr_pkg::*;

	localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	logic [MAX_SLOTS-1:0][7:0] all_keys;
	logic [KEY_SLOTS-1:0][7:0] keys;
	logic [KEY_SLOTS-1:0][7:0] prev_q;

	slot_t                 info      [KEY_SLOTS];
	logic [KEY_SLOTS-1:0]  seq_mask;
	logic [KEY_SLOTS-1:0]  chr_mask;

	slot_t                 info_s1   [KEY_SLOTS];
	logic [KEY_SLOTS-1:0]  seq_mask_s1;
	logic [KEY_SLOTS-1:0]  chr_mask_s1;
	logic [2:0]            pos_s1;

	logic                  byte_valid_q;
	logic [6:0]            out_byte_q;
	logic                  last_q;

	logic                  accept;
	logic                  ignore;
	logic                  busy;
	logic                  adv;
	logic                  cur_seq;
	logic [SLOT_W-1:0]     idx;
	seq_t                  seq;
	logic [6:0]            cur_byte;
	logic                  entry_end;
	logic [KEY_SLOTS-1:0]  seq_mask_nx;
	logic [KEY_SLOTS-1:0]  chr_mask_nx;
	logic                  last_now;

	assign all_keys = {key_5, key_4, key_3, key_2, key_1, key_0};
	assign keys     = all_keys[KEY_SLOTS-1:0];
	assign ignore   = short_report || (key_0 == KC_ROLLOVER);

	hkr_classify #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_classify (
		.keys    (keys),
		.prev    (prev_q),
		.mods    (modifier_mask),
		.info    (info),
		.seq_mask(seq_mask),
		.chr_mask(chr_mask)
	);

	// emitter: escape slots drain first, then character slots
	always_comb begin
		busy    = |seq_mask_s1 || |chr_mask_s1;
		cur_seq = |seq_mask_s1;
		idx     = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--)
			if (cur_seq ? seq_mask_s1[i] : chr_mask_s1[i])
				idx = SLOT_W'(i);
		seq         = seq_lookup(info_s1[idx].seq_idx);
		cur_byte    = cur_seq ? seq.b[pos_s1] : info_s1[idx].chr;
		entry_end   = cur_seq ? (pos_s1 == 3'(seq.len - 3'd1)) : 1'b1;
		seq_mask_nx = seq_mask_s1;
		chr_mask_nx = chr_mask_s1;
		if (entry_end) begin
			if (cur_seq)
				seq_mask_nx[idx] = 1'b0;
			else
				chr_mask_nx[idx] = 1'b0;
		end
		last_now = entry_end && !(|seq_mask_nx) && !(|chr_mask_nx);
	end

	assign adv          = !byte_valid_q || !byte_stall;
	assign report_stall = busy && !(adv && last_now);
	assign accept       = report_valid && !report_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			seq_mask_s1 <= '0;
			chr_mask_s1 <= '0;
			pos_s1      <= '0;
		end else if (accept) begin
			pos_s1 <= '0;
			if (ignore) begin
				seq_mask_s1 <= '0;
				chr_mask_s1 <= '0;
			end else begin
				seq_mask_s1 <= seq_mask;
				chr_mask_s1 <= chr_mask;
				prev_q      <= keys;
			end
		end else if (adv && busy) begin
			seq_mask_s1 <= seq_mask_nx;
			chr_mask_s1 <= chr_mask_nx;
			pos_s1      <= entry_end ? 3'd0 : 3'(pos_s1 + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			info_s1 <= info;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_valid_q <= 1'b0;
		else if (adv)
			byte_valid_q <= busy;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= cur_byte;
			last_q     <= last_now;
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_q;

	// a report only enters when the emitter is empty or handing off its final byte
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && busy) |-> (adv && last_now))
		else $error("report taken while emitter still has bytes");

	// a non-final byte leaves work behind for the next cycle
	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy && !last_now) |=> busy)
		else $error("emitter drained without flagging last byte");

	// every emitted byte is a real character
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> (out_byte != 7'd0))
		else $error("null byte emitted");

	// ignored reports leave the stored key set alone
	a_ignore_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ignore) |=> $stable(prev_q))
		else $error("stored keys changed by an ignored report");

	// escape byte position never runs past a five-byte sequence
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pos_s1 < 3'd5))
		else $error("sequence position out of range");

endmodule
